FILE: sv/mkdlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkdlp_pkg
// shared types and constants for the multi-key debounce and long-press block
// ----------------------------------------------------------------------------
package mkdlp_pkg;

    localparam int NUM_KEYS_DEFAULT = 5;
    localparam int STAMP_W          = 32;
    localparam int TIME_W           = 16;
    localparam int KEY_FIELD_W      = 3;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = TIME_W'(50);
    localparam logic [TIME_W-1:0] LONG_PRESS_RESET = TIME_W'(2000);

    // per-key status toward the key picker
    typedef struct packed {
        logic short_cand;
        logic long_fire;
    } lane_stat_t;

endpackage : mkdlp_pkg
`default_nettype wire

FILE: sv/mkdlp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkdlp interfaces
// poll, result and configuration channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface mkdlp_poll_if #(
    parameter int NUM_KEYS = mkdlp_pkg::NUM_KEYS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic [NUM_KEYS-1:0]           raw_levels;
    logic [mkdlp_pkg::STAMP_W-1:0] now_ms;

    modport source (output valid, output raw_levels, output now_ms, input ready);
    modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface : mkdlp_poll_if

interface mkdlp_result_if;
    logic                              valid;
    logic                              ready;
    logic                              short_valid;
    logic [mkdlp_pkg::KEY_FIELD_W-1:0] short_key;
    logic                              long_valid;
    logic [mkdlp_pkg::KEY_FIELD_W-1:0] long_key;

    modport source (output valid, output short_valid, output short_key,
                    output long_valid, output long_key, input ready);
    modport sink   (input valid, input short_valid, input short_key,
                    input long_valid, input long_key, output ready);
endinterface : mkdlp_result_if

interface mkdlp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mkdlp_pkg::CFG_IDX_W-1:0]  index;
    logic [mkdlp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : mkdlp_cfg_if
`default_nettype wire

FILE: sv/mkdlp_key_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkdlp_key_lane
// debounce, press stamp and long-press state of one key
// ----------------------------------------------------------------------------
module mkdlp_key_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          update,
    input  wire logic                          raw,
    input  wire logic [mkdlp_pkg::STAMP_W-1:0] now_ms,
    input  wire logic [mkdlp_pkg::TIME_W-1:0]  debounce_time,
    input  wire logic [mkdlp_pkg::TIME_W-1:0]  long_press_time,
    input  wire logic                          grant,
    output mkdlp_pkg::lane_stat_t              stat
);
    import mkdlp_pkg::*;

    logic               sampled_reg, sampled_next;
    logic               stable_reg, stable_next;
    logic [STAMP_W-1:0] change_reg, change_next;
    logic [STAMP_W-1:0] press_reg, press_next;
    logic               reported_reg, reported_next;
    logic               fired_reg, fired_next;

    logic               changed;
    logic               accept;
    logic               rising;
    logic               falling;
    logic               fired_mid;
    logic               reported_mid;
    logic               long_fire;
    logic [STAMP_W-1:0] held;

    always_comb
    begin
        changed      = raw != sampled_reg;
        sampled_next = raw;
        change_next  = changed ? now_ms : change_reg;
        accept       = (now_ms - change_next) >= STAMP_W'(debounce_time);
        rising       = accept && raw && !stable_reg;
        falling      = accept && !raw && stable_reg;
        stable_next  = accept ? raw : stable_reg;
        press_next   = rising ? now_ms : press_reg;
        fired_mid    = (rising || falling) ? 1'b0 : fired_reg;
        reported_mid = falling ? 1'b0 : reported_reg;
        held         = now_ms - press_next;
        long_fire    = accept && raw && !fired_mid && (held >= STAMP_W'(long_press_time));
        fired_next   = fired_mid || long_fire;
        stat.long_fire  = long_fire;
        stat.short_cand = stable_next && !reported_mid && !fired_next
                          && (held < STAMP_W'(long_press_time));
        reported_next   = reported_mid || grant;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_reg  <= 1'b0;
            stable_reg   <= 1'b0;
            change_reg   <= '0;
            press_reg    <= '0;
            reported_reg <= 1'b0;
            fired_reg    <= 1'b0;
        end
        else if (update)
        begin
            sampled_reg  <= sampled_next;
            stable_reg   <= stable_next;
            change_reg   <= change_next;
            press_reg    <= press_next;
            reported_reg <= reported_next;
            fired_reg    <= fired_next;
        end
    end

endmodule : mkdlp_key_lane
`default_nettype wire

FILE: sv/mkdlp_picker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkdlp_picker
// lowest short-press candidate and highest long-press event across keys
// ----------------------------------------------------------------------------
module mkdlp_picker #(
    parameter int NUM_KEYS = mkdlp_pkg::NUM_KEYS_DEFAULT
) (
    input  wire mkdlp_pkg::lane_stat_t [NUM_KEYS-1:0] stat,
    output logic [NUM_KEYS-1:0]                    grant,
    output logic                                   short_valid,
    output logic [mkdlp_pkg::KEY_FIELD_W-1:0]      short_key,
    output logic                                   long_valid,
    output logic [mkdlp_pkg::KEY_FIELD_W-1:0]      long_key
);
    import mkdlp_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EXT_W = (KEY_W > KEY_FIELD_W) ? KEY_W : KEY_FIELD_W;

    logic [KEY_W-1:0] short_idx;
    logic [KEY_W-1:0] long_idx;
    logic [EXT_W-1:0] short_ext;
    logic [EXT_W-1:0] long_ext;

    always_comb
    begin
        short_valid = 1'b0;
        short_idx   = '0;
        grant       = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (stat[i].short_cand)
            begin
                short_valid = 1'b1;
                short_idx   = KEY_W'(i);
            end
        end
        if (short_valid)
        begin
            grant[short_idx] = 1'b1;
        end
    end

    always_comb
    begin
        long_valid = 1'b0;
        long_idx   = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (stat[i].long_fire)
            begin
                long_valid = 1'b1;
                long_idx   = KEY_W'(i);
            end
        end
    end

    assign short_ext = EXT_W'(short_idx);
    assign long_ext  = EXT_W'(long_idx);
    assign short_key = short_ext[KEY_FIELD_W-1:0];
    assign long_key  = long_ext[KEY_FIELD_W-1:0];

endmodule : mkdlp_picker
`default_nettype wire

FILE: sv/multi_key_debounce_long_press.sv
`default_nettype none
// a poll waits in the input stage, and its result word is registered in the output stage
// throughput: one poll per cycle if not stalled; key lanes update as a poll leaves the input stage
// the input stage keeps taking polls while a result waits, until both stages are full
// reset: asynchronous, clears all key state, both stages empty,
// debounce time 50 ms and long-press time 2000 ms
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press
// per-key debounce with short-press report and long-press event per poll
// ----------------------------------------------------------------------------
module multi_key_debounce_long_press #(
    parameter int NUM_KEYS = mkdlp_pkg::NUM_KEYS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    mkdlp_poll_if.sink             poll,
    mkdlp_result_if.source         result,
    mkdlp_cfg_if.sink              cfg
);
    import mkdlp_pkg::*;

    logic [TIME_W-1:0] debounce_reg;
    logic [TIME_W-1:0] long_press_reg;

    logic                s1_valid_reg, s1_valid_next;
    logic [NUM_KEYS-1:0] s1_levels_reg;
    logic [STAMP_W-1:0]  s1_now_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_short_valid_reg;
    logic [KEY_FIELD_W-1:0] out_short_key_reg;
    logic                   out_long_valid_reg;
    logic [KEY_FIELD_W-1:0] out_long_key_reg;

    logic out_load;
    logic s1_fire;
    logic poll_take;

    lane_stat_t [NUM_KEYS-1:0] stat;
    logic [NUM_KEYS-1:0]       grant;
    logic                      pick_short_valid;
    logic [KEY_FIELD_W-1:0]    pick_short_key;
    logic                      pick_long_valid;
    logic [KEY_FIELD_W-1:0]    pick_long_key;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE:   debounce_reg   <= cfg.data;
                REG_LONG_PRESS: long_press_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // handshake
    assign out_load   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && out_load;
    assign poll.ready = !s1_valid_reg || out_load;
    assign poll_take  = poll.valid && poll.ready;

    always_comb
    begin
        s1_valid_next  = poll_take || (s1_valid_reg && !s1_fire);
        out_valid_next = s1_fire || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            s1_levels_reg <= poll.raw_levels;
            s1_now_reg    <= poll.now_ms;
        end
        if (s1_fire)
        begin
            out_short_valid_reg <= pick_short_valid;
            out_short_key_reg   <= pick_short_key;
            out_long_valid_reg  <= pick_long_valid;
            out_long_key_reg    <= pick_long_key;
        end
    end

    // key lanes
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        mkdlp_key_lane u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .update          (s1_fire),
            .raw             (s1_levels_reg[k]),
            .now_ms          (s1_now_reg),
            .debounce_time   (debounce_reg),
            .long_press_time (long_press_reg),
            .grant           (grant[k]),
            .stat            (stat[k])
        );
    end

    mkdlp_picker #(
        .NUM_KEYS (NUM_KEYS)
    ) u_picker (
        .stat        (stat),
        .grant       (grant),
        .short_valid (pick_short_valid),
        .short_key   (pick_short_key),
        .long_valid  (pick_long_valid),
        .long_key    (pick_long_key)
    );

    assign result.valid       = out_valid_reg;
    assign result.short_valid = out_short_valid_reg;
    assign result.short_key   = out_short_key_reg;
    assign result.long_valid  = out_long_valid_reg;
    assign result.long_key    = out_long_key_reg;

endmodule : multi_key_debounce_long_press
`default_nettype wire

FILE: sv/mkdlp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkdlp_checker
// port-level checks on the result channel of the debounce block
// ----------------------------------------------------------------------------
module mkdlp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              res_valid,
    input wire logic                              res_ready,
    input wire logic                              short_valid,
    input wire logic [mkdlp_pkg::KEY_FIELD_W-1:0] short_key,
    input wire logic                              long_valid,
    input wire logic [mkdlp_pkg::KEY_FIELD_W-1:0] long_key
);
    import mkdlp_pkg::*;

    // no short press reported means key field zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !short_valid |-> short_key == '0)
        else $error("short_key not zero without short press");

    // no long press means key field zero
    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !long_valid |-> long_key == '0)
        else $error("long_key not zero without long press");

    // a key that fires long in a poll is never reported short in that poll
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && short_valid && long_valid |-> short_key != long_key)
        else $error("same key reported short and long");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(short_valid)
            && $stable(short_key) && $stable(long_valid) && $stable(long_key))
        else $error("result word changed while stalled");

endmodule : mkdlp_checker

bind multi_key_debounce_long_press mkdlp_checker u_mkdlp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .short_valid (result.short_valid),
    .short_key   (result.short_key),
    .long_valid  (result.long_valid),
    .long_key    (result.long_key)
);
`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// drives polls of five key levels with a running millisecond stamp into the
// debounce block, predicts the short-press and long-press word of every poll
// with its own per-key state, and compares each result word in order; the
// run steps through several debounce and long-press settings, both extremes
// included, with random gaps on the poll and result sides
// ----------------------------------------------------------------------------
module tb_top;

    import mkdlp_pkg::*;

    localparam int NK    = NUM_KEYS_DEFAULT;
    localparam int LIMIT = 300000;
    localparam int KI_W  = (NK > 1) ? $clog2(NK) : 1;

    typedef struct packed {
        logic                   short_valid;
        logic [KEY_FIELD_W-1:0] short_key;
        logic                   long_valid;
        logic [KEY_FIELD_W-1:0] long_key;
    } key_event_t;

    class debounce_scoreboard;
        logic [TIME_W-1:0] db_time;
        logic [TIME_W-1:0] lp_time;
        bit [NK-1:0]       seen_lv;
        bit [NK-1:0]       stable;
        bit [NK-1:0]       rep;
        bit [NK-1:0]       lfire;
        bit [31:0]         chg_at[NK];
        bit [31:0]         press_at[NK];
        key_event_t        due[$];
        int                errors;
        int                polls;
        int                shorts;
        int                longs;

        function new();
            db_time  = DEBOUNCE_RESET;
            lp_time  = LONG_PRESS_RESET;
            seen_lv  = '0;
            stable   = '0;
            rep      = '0;
            lfire    = '0;
            foreach (chg_at[i])
            begin
                chg_at[i]   = '0;
                press_at[i] = '0;
            end
            errors = 0;
            polls  = 0;
            shorts = 0;
            longs  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DEBOUNCE)
                db_time = val;
            else if (idx == REG_LONG_PRESS)
                lp_time = val;
        endfunction

        function void note_poll(logic [NK-1:0] lv, logic [31:0] t);
            key_event_t ev;
            bit [31:0]  since;
            ev = '0;
            for (int i = 0; i < NK; i++)
            begin
                if (lv[i] != seen_lv[i])
                begin
                    chg_at[i]  = t;
                    seen_lv[i] = lv[i];
                end
                since = t - chg_at[i];
                if (since >= 32'(db_time))
                begin
                    if (lv[i] && !stable[i])
                    begin
                        press_at[i] = t;
                        lfire[i]    = 1'b0;
                    end
                    if (!lv[i] && stable[i])
                    begin
                        rep[i]   = 1'b0;
                        lfire[i] = 1'b0;
                    end
                    stable[i] = lv[i];
                    since = t - press_at[i];
                    if (lv[i] && !lfire[i] && since >= 32'(lp_time))
                    begin
                        lfire[i]      = 1'b1;
                        ev.long_valid = 1'b1;
                        ev.long_key   = KEY_FIELD_W'(i);
                    end
                end
            end
            // lowest eligible key gets the short report
            for (int i = 0; i < NK; i++)
            begin
                since = t - press_at[i];
                if (!ev.short_valid && stable[i] && !rep[i] && !lfire[i] &&
                    since < 32'(lp_time))
                begin
                    rep[i]         = 1'b1;
                    ev.short_valid = 1'b1;
                    ev.short_key   = KEY_FIELD_W'(i);
                end
            end
            due.push_back(ev);
            polls++;
        endfunction

        function void flag(string what, key_event_t want, key_event_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected short %0b/%0d long %0b/%0d, got short %0b/%0d long %0b/%0d",
                         $time, what, want.short_valid, want.short_key, want.long_valid,
                         want.long_key, got.short_valid, got.short_key, got.long_valid,
                         got.long_key);
        endfunction

        function void check_result(key_event_t got);
            key_event_t want;
            if (due.size() == 0)
            begin
                flag("word with nothing expected", '0, got);
                return;
            end
            want = due.pop_front();
            if (got.short_valid !== want.short_valid)
                flag("short_valid", want, got);
            else if (got.short_key !== want.short_key)
                flag("short_key", want, got);
            else if (got.long_valid !== want.long_valid)
                flag("long_valid", want, got);
            else if (got.long_key !== want.long_key)
                flag("long_key", want, got);
            if (got.short_valid === 1'b1)
                shorts++;
            if (got.long_valid === 1'b1)
                longs++;
        endfunction

        function void close_out();
            if (due.size() != 0)
            begin
                errors++;
                $display("%0t: %0d words never arrived", $time, due.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mkdlp_poll_if #(.NUM_KEYS(NK)) poll_if ();
    mkdlp_result_if                res_if ();
    mkdlp_cfg_if                   cfg_if ();

    multi_key_debounce_long_press #(
        .NUM_KEYS (NK)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    debounce_scoreboard sb = new();

    bit [31:0] clock_ms;
    int        src_gap_pct;
    int        snk_gap_pct;
    bit        stall_req;
    int        hold_cnt;
    int        cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, sb.due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: random ready, with a counted hold-off on request
    always @(negedge clk)
    begin
        if (stall_req)
        begin
            stall_req = 1'b0;
            hold_cnt  = 40;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(key_event_t'{res_if.short_valid, res_if.short_key,
                                         res_if.long_valid, res_if.long_key});
    end

    task automatic send_poll(input logic [NK-1:0] lv, input logic [31:0] t);
        @(negedge clk);
        if ($urandom_range(99) < src_gap_pct)
        begin
            poll_if.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_gap_pct);
        end
        poll_if.valid      <= 1'b1;
        poll_if.raw_levels <= lv;
        poll_if.now_ms     <= t;
        @(posedge clk);
        while (poll_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_poll(lv, t);
    endtask

    task automatic step(input bit [31:0] dt, input logic [NK-1:0] lv);
        clock_ms += dt;
        send_poll(lv, clock_ms);
    endtask

    task automatic poll_idle();
        @(negedge clk);
        poll_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int           db_set[6];
        int           lp_set[6];
        int           r;
        int unsigned  scale;
        bit [NK-1:0]  held;
        logic [KI_W-1:0] kidx;

        db_set = '{5, 0, 65535, 20, 1, 0};
        lp_set = '{40, 30, 65535, 0, 1, 65535};

        rst_n              = 1'b0;
        poll_if.valid      = 1'b0;
        poll_if.raw_levels = '0;
        poll_if.now_ms     = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        src_gap_pct        = 8;
        snk_gap_pct        = 52;
        stall_req          = 1'b0;
        hold_cnt           = 0;
        cycles             = 0;
        clock_ms           = '0;
        held               = '0;
        kidx               = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: press, short, long, multi-key, release, bounce
        step(0, 5'h00);
        step(10, 5'h01);
        step(50, 5'h01);
        step(2000, 5'h01);
        step(5, 5'h1F);
        step(60, 5'h1F);
        step(1, 5'h1F);
        step(2000, 5'h1F);
        step(1, 5'h00);
        step(60, 5'h00);
        step(3, 5'h10);
        step(3, 5'h00);
        step(3, 5'h10);
        step(49, 5'h10);
        step(1, 5'h10);
        // stamp going backwards
        step(32'hFFFF_FC18, 5'h18);
        step(70, 5'h18);
        // stamp wrapping through zero
        clock_ms = 32'hFFFF_FFF0;
        step(0, 5'h02);
        step(15, 5'h02);
        step(60, 5'h02);
        poll_idle();
        drain();

        // both times zero: accepted at once, long at once, never short
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_LONG_PRESS, '0);
        step(1, 5'h0A);
        step(1, 5'h0A);
        step(1, 5'h00);
        step(1, 5'h1F);
        poll_idle();
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_DEBOUNCE, CFG_DATA_W'(db_set[p]));
            write_reg(REG_LONG_PRESS, CFG_DATA_W'(lp_set[p]));
            src_gap_pct = (p < 2) ? 8 : (p < 4) ? 52 : 0;
            snk_gap_pct = (p < 2) ? 52 : (p < 4) ? 8 : 0;
            if (p == 0 || p == 4)
                stall_req = 1'b1;
            scale = (db_set[p] > lp_set[p]) ? db_set[p] : lp_set[p];
            if (scale < 4)
                scale = 4;
            repeat (112)
            begin
                r = $urandom_range(99);
                if (r < 8)
                begin
                    held = NK'($urandom);
                    step($urandom, held);
                end
                else if (r < 22)
                begin
                    kidx = KI_W'($urandom_range(NK-1));
                    held[kidx] ^= 1'b1;
                    step($urandom_range(scale / 8 + 1), held);
                end
                else
                begin
                    step($urandom_range(scale / 3 + 1), held);
                end
            end
            poll_idle();
            drain();
        end

        sb.close_out();
        $display("summary: %0d polls over 8 register settings, %0d short reports, %0d long events",
                 sb.polls, sb.shorts, sb.longs);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule : tb_top
`default_nettype wire
